// ===== rtl/osf_pkg.sv =====
// ----------------------------------------------------------------------------
// osf_pkg: shared definitions for the open spline flattener
// Default sizes, register indexes, the datapath opcode and the stack command.
// ----------------------------------------------------------------------------
package osf_pkg;

  // Default sizes
  localparam int COORD_BITS_DEF    = 16;
  localparam int FRAC_BITS_DEF     = 8;
  localparam int STACK_ENTRIES_DEF = 8;

  // Controls per piece: start, two inner controls, end (x and y each)
  localparam int NUM_COORDS = 8;

  // Subdivision level and depth limit
  localparam int HARD_DEPTH = 4;
  localparam int LVL_W      = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int THR_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT    = 2'd1;

  localparam logic [THR_W-1:0] THR_RESET   = 8'd5;
  localparam logic [LVL_W-1:0] DEPTH_RESET = 3'd4;

  // Shared datapath operation
  typedef enum logic [0:0] {
    ALU_MID,   // floor((a + b) / 2)
    ALU_DIFF   // |a - b| < threshold
  } alu_op_e;

  // Piece stack command
  typedef struct packed {
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

// ===== rtl/osf_alu.sv =====
// ----------------------------------------------------------------------------
// osf_alu: shared two-lane midpoint / distance unit
// One adder per lane does either the midpoint sum or the difference that
// feeds the flatness compare against the threshold.
// ----------------------------------------------------------------------------
module osf_alu #(
  parameter int RW = osf_pkg::COORD_BITS_DEF + osf_pkg::FRAC_BITS_DEF
) (
  input  osf_pkg::alu_op_e op_i,
  input  logic signed [RW-1:0] a_x_i,
  input  logic signed [RW-1:0] b_x_i,
  input  logic signed [RW-1:0] a_y_i,
  input  logic signed [RW-1:0] b_y_i,
  input  logic [RW:0]          thr_i,
  output logic signed [RW-1:0] mid_x_o,
  output logic signed [RW-1:0] mid_y_o,
  output logic                 lt_o
);
  import osf_pkg::*;

  logic          sub;
  logic [RW:0]   ax, bx, ay, by;
  logic [RW:0]   sum_x, sum_y;
  logic [RW:0]   mag_x, mag_y;

  assign sub = (op_i == ALU_DIFF);

  assign ax = {a_x_i[RW-1], a_x_i};
  assign ay = {a_y_i[RW-1], a_y_i};
  assign bx = sub ? ~{b_x_i[RW-1], b_x_i} : {b_x_i[RW-1], b_x_i};
  assign by = sub ? ~{b_y_i[RW-1], b_y_i} : {b_y_i[RW-1], b_y_i};

  assign sum_x = ax + bx + {{RW{1'b0}}, sub};
  assign sum_y = ay + by + {{RW{1'b0}}, sub};

  // arithmetic shift right by one of the exact sum
  assign mid_x_o = sum_x[RW:1];
  assign mid_y_o = sum_y[RW:1];

  assign mag_x = sum_x[RW] ? (~sum_x + 1'b1) : sum_x;
  assign mag_y = sum_y[RW] ? (~sum_y + 1'b1) : sum_y;

  assign lt_o = (mag_x < thr_i) && (mag_y < thr_i);

endmodule

// ===== rtl/osf_stack.sv =====
// ----------------------------------------------------------------------------
// osf_stack: piece stack for depth-first subdivision
// One row per piece; push writes the top, pop reads it into a register.
// ----------------------------------------------------------------------------
module osf_stack #(
  parameter int DEPTH = osf_pkg::STACK_ENTRIES_DEF,
  parameter int WIDTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  osf_pkg::stk_cmd_t  cmd_i,
  input  logic [WIDTH-1:0]   wdata_i,
  output logic [WIDTH-1:0]   rdata_o,
  output logic               empty_o
);
  import osf_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PtrW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  ptr_q;
  logic [PtrW-1:0]  ptr_m1;
  logic [WIDTH-1:0] rdata_q;
  logic             full;

  assign ptr_m1  = ptr_q - PtrW'(1);
  assign empty_o = (ptr_q == '0);
  assign full    = (ptr_q == PtrW'(DEPTH));
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[ptr_q[IdxW-1:0]] <= wdata_i;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[ptr_m1[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.push) begin
      ptr_q <= ptr_q + PtrW'(1);
    end else if (cmd_i.pop) begin
      ptr_q <= ptr_m1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !full) else $error("osf_stack: push on full stack");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !empty_o) else $error("osf_stack: pop on empty stack");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && cmd_i.pop)) else $error("osf_stack: push and pop together");

endmodule

// ===== rtl/open_spline_flattener.sv =====
// ----------------------------------------------------------------------------
// open_spline_flattener: open spline to polyline converter
// Flattens curve segments built from control point midpoints by stack-based
// midpoint subdivision and streams out the polyline vertices.
// ----------------------------------------------------------------------------
// Feed the control points of an open spline one beat at a time and mark the
// final point with last_point_i; each input beat produces zero or more vertex
// beats, and the final vertex beat of an input carries out_last_o. The first
// point comes out as is, the second only loads the carried controls, and each
// later point flattens one curve segment. A piece counts as flat when its
// start and end both lie within flat_threshold pixels, on each axis, of the
// midpoint of its inner controls; pieces at the depth limit (register value
// capped at 4 and at STACK_ENTRIES - 1) come out as flat, with depth_capped_o
// set unless they are flat. Coordinates run internally with FRAC_BITS
// fraction bits and are truncated toward zero on output. Timing: all
// arithmetic goes through one two-lane adder under the sequencer, one
// operation per cycle, so the block takes a new point only when the previous
// one is fully done. Each flat piece and each piece at the depth limit
// emits its start and the midpoint of its inner controls; the final point
// adds the carried midpoint and the endpoint. At depth limit 4 with no flat
// piece a segment yields 32 vertices. Output stalls hold the sequencer in
// its vertex states. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module open_spline_flattener #(
  parameter int COORD_BITS    = osf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS     = osf_pkg::FRAC_BITS_DEF,
  parameter int STACK_ENTRIES = osf_pkg::STACK_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [osf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [osf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // control point channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  input  logic                              last_point_i,
  // vertex channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [COORD_BITS-1:0]      out_x_o,
  output logic signed [COORD_BITS-1:0]      out_y_o,
  output logic                              out_last_o,
  output logic                              depth_capped_o
);
  import osf_pkg::*;

  localparam int RW     = COORD_BITS + FRAC_BITS;
  localparam int RowW   = NUM_COORDS * RW + LVL_W;
  localparam int LimCap = (STACK_ENTRIES - 1 < HARD_DEPTH) ? STACK_ENTRIES - 1 : HARD_DEPTH;

  typedef logic signed [RW-1:0] raw_t;

  localparam raw_t RoundBias = raw_t'((1 << FRAC_BITS) - 1);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EMIT_IN,
    ST_CARRY_A,
    ST_CARRY_B,
    ST_SEG_A,
    ST_SEG_B,
    ST_PUSH_SEG,
    ST_POP,
    ST_MID,
    ST_CHK0,
    ST_CHK1,
    ST_LEAF0,
    ST_LEAF1,
    ST_SP_R2,
    ST_SP_R4,
    ST_SP_L2,
    ST_SP_L4,
    ST_PUSH_R,
    ST_PUSH_L,
    ST_CARRY_U,
    ST_TAIL_MID,
    ST_TAIL_END
  } state_e;

  // Truncate a raw coordinate toward zero to whole pixels.
  function automatic logic [COORD_BITS-1:0] to_pixel(input raw_t raw);
    raw_t biased;
    biased = raw + (raw[RW-1] ? RoundBias : raw_t'(0));
    return biased[RW-1:FRAC_BITS];
  endfunction

  // Configuration registers
  logic [THR_W-1:0] cfg_thr_q;
  logic [LVL_W-1:0] cfg_depth_q;
  logic [LVL_W-1:0] lim;
  logic [RW:0]      thr;

  // Sequencer state and working registers (index 0 is x, 1 is y)
  state_e       state_q;
  logic [1:0]   points_seen_q;
  logic         last_q;
  logic         f_q;
  logic         cap_q;
  raw_t         p_q     [2];
  raw_t         prev_q  [2];
  raw_t         carry_q [4];
  raw_t         e4_q    [2];
  raw_t         e6_q    [2];
  raw_t         m_q     [2];
  raw_t         n2_q    [2];
  raw_t         n4_q    [2];
  raw_t         k2_q    [2];
  raw_t         k4_q    [2];

  // Output register
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                  out_last_q, out_capped_q;

  // Shared unit
  alu_op_e alu_op;
  raw_t    alu_ax, alu_bx, alu_ay, alu_by;
  raw_t    alu_mx, alu_my;
  logic    alu_lt;

  // Piece stack
  stk_cmd_t         stk_cmd;
  logic [RowW-1:0]  stk_wdata, stk_rdata;
  logic             stk_empty;
  raw_t             pc [NUM_COORDS];
  logic [LVL_W-1:0] pc_lvl;
  logic [LVL_W-1:0] child_lvl;

  // Vertex selection
  logic emit_req, emit_ok, emit_last, emit_capped;
  raw_t emit_x, emit_y;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  assign lim = (cfg_depth_q > LVL_W'(LimCap)) ? LVL_W'(LimCap) : cfg_depth_q;
  assign thr = (RW + 1)'({cfg_thr_q, {FRAC_BITS{1'b0}}});

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_thr_q   <= THR_RESET;
      cfg_depth_q <= DEPTH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FLAT_THRESHOLD: cfg_thr_q   <= cfg_data_i;
        CFG_DEPTH_LIMIT:    cfg_depth_q <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the popped piece; it stays in the stack read register until the
  // next pop.
  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      pc[k] = stk_rdata[k*RW +: RW];
    end
    pc_lvl = stk_rdata[NUM_COORDS*RW +: LVL_W];
  end

  assign child_lvl = pc_lvl + LVL_W'(1);

  // Operand selection for the shared unit
  always_comb begin
    alu_op = ALU_MID;
    alu_ax = prev_q[0];
    alu_ay = prev_q[1];
    alu_bx = p_q[0];
    alu_by = p_q[1];
    case (state_q)
      ST_CARRY_B: begin
        alu_ax = carry_q[0];
        alu_ay = carry_q[1];
      end
      ST_SEG_B: begin
        alu_bx = e6_q[0];
        alu_by = e6_q[1];
      end
      ST_MID: begin
        alu_ax = pc[2];
        alu_ay = pc[3];
        alu_bx = pc[4];
        alu_by = pc[5];
      end
      ST_CHK0: begin
        alu_op = ALU_DIFF;
        alu_ax = pc[0];
        alu_ay = pc[1];
        alu_bx = m_q[0];
        alu_by = m_q[1];
      end
      ST_CHK1: begin
        alu_op = ALU_DIFF;
        alu_ax = m_q[0];
        alu_ay = m_q[1];
        alu_bx = pc[6];
        alu_by = pc[7];
      end
      ST_SP_R2: begin
        alu_ax = m_q[0];
        alu_ay = m_q[1];
        alu_bx = pc[4];
        alu_by = pc[5];
      end
      ST_SP_R4: begin
        alu_ax = pc[4];
        alu_ay = pc[5];
        alu_bx = pc[6];
        alu_by = pc[7];
      end
      ST_SP_L2: begin
        alu_ax = pc[0];
        alu_ay = pc[1];
        alu_bx = pc[2];
        alu_by = pc[3];
      end
      ST_SP_L4: begin
        alu_ax = pc[2];
        alu_ay = pc[3];
        alu_bx = m_q[0];
        alu_by = m_q[1];
      end
      ST_CARRY_U: begin
        alu_ax = e6_q[0];
        alu_ay = e6_q[1];
      end
      default: ;
    endcase
  end

  osf_alu #(
    .RW (RW)
  ) u_alu (
    .op_i    (alu_op),
    .a_x_i   (alu_ax),
    .b_x_i   (alu_bx),
    .a_y_i   (alu_ay),
    .b_y_i   (alu_by),
    .thr_i   (thr),
    .mid_x_o (alu_mx),
    .mid_y_o (alu_my),
    .lt_o    (alu_lt)
  );

  // Stack commands and row to push
  always_comb begin
    stk_cmd.push = (state_q == ST_PUSH_SEG) || (state_q == ST_PUSH_R) ||
                   (state_q == ST_PUSH_L);
    stk_cmd.pop  = (state_q == ST_POP);
    case (state_q)
      ST_PUSH_SEG: stk_wdata = {LVL_W'(0), e6_q[1], e6_q[0], e4_q[1], e4_q[0],
                                carry_q[3], carry_q[2], carry_q[1], carry_q[0]};
      ST_PUSH_R:   stk_wdata = {child_lvl, pc[7], pc[6], n4_q[1], n4_q[0],
                                n2_q[1], n2_q[0], m_q[1], m_q[0]};
      ST_PUSH_L:   stk_wdata = {child_lvl, m_q[1], m_q[0], k4_q[1], k4_q[0],
                                k2_q[1], k2_q[0], pc[1], pc[0]};
      default:     stk_wdata = '0;
    endcase
  end

  osf_stack #(
    .DEPTH (STACK_ENTRIES),
    .WIDTH (RowW)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stk_cmd),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata),
    .empty_o (stk_empty)
  );

  // Vertex to emit in the current state
  always_comb begin
    emit_req    = 1'b0;
    emit_x      = p_q[0];
    emit_y      = p_q[1];
    emit_last   = 1'b0;
    emit_capped = 1'b0;
    case (state_q)
      ST_EMIT_IN: begin
        emit_req  = 1'b1;
        emit_last = 1'b1;
      end
      ST_LEAF0: begin
        emit_req    = 1'b1;
        emit_x      = pc[0];
        emit_y      = pc[1];
        emit_capped = cap_q;
      end
      ST_LEAF1: begin
        // the final flat piece ends the item unless the endpoint follows
        emit_req    = 1'b1;
        emit_x      = m_q[0];
        emit_y      = m_q[1];
        emit_capped = cap_q;
        emit_last   = stk_empty && !last_q;
      end
      ST_TAIL_MID: begin
        emit_req = 1'b1;
        emit_x   = carry_q[0];
        emit_y   = carry_q[1];
      end
      ST_TAIL_END: begin
        emit_req  = 1'b1;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign emit_ok = !out_valid_q || out_ready_i;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      points_seen_q <= 2'd0;
      last_q        <= 1'b0;
      f_q           <= 1'b0;
      cap_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      prev_q        <= '{default: '0};
      carry_q       <= '{default: '0};
    end else begin
      // output register: load a new vertex beat or drop the taken one
      if (emit_req && emit_ok) begin
        out_valid_q  <= 1'b1;
        out_x_q      <= to_pixel(emit_x);
        out_y_q      <= to_pixel(emit_y);
        out_last_q   <= emit_last;
        out_capped_q <= emit_capped;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            p_q[0] <= {point_x_i, {FRAC_BITS{1'b0}}};
            p_q[1] <= {point_y_i, {FRAC_BITS{1'b0}}};
            last_q <= last_point_i;
            case (points_seen_q)
              2'd0:    state_q <= ST_EMIT_IN;
              2'd1:    state_q <= ST_CARRY_A;
              default: state_q <= ST_SEG_A;
            endcase
          end
        end
        ST_EMIT_IN: begin
          if (emit_ok) begin
            prev_q        <= p_q;
            points_seen_q <= last_q ? 2'd0 : 2'd1;
            state_q       <= ST_IDLE;
          end
        end
        // second point: load the carried controls
        ST_CARRY_A: begin
          carry_q[0] <= alu_mx;
          carry_q[1] <= alu_my;
          state_q    <= ST_CARRY_B;
        end
        ST_CARRY_B: begin
          carry_q[2]    <= alu_mx;
          carry_q[3]    <= alu_my;
          prev_q        <= p_q;
          points_seen_q <= 2'd2;
          state_q       <= last_q ? ST_TAIL_MID : ST_IDLE;
        end
        // later points: build the segment end controls
        ST_SEG_A: begin
          e6_q[0] <= alu_mx;
          e6_q[1] <= alu_my;
          state_q <= ST_SEG_B;
        end
        ST_SEG_B: begin
          e4_q[0] <= alu_mx;
          e4_q[1] <= alu_my;
          state_q <= ST_PUSH_SEG;
        end
        ST_PUSH_SEG: state_q <= ST_POP;
        ST_POP:      state_q <= ST_MID;
        ST_MID: begin
          m_q[0]  <= alu_mx;
          m_q[1]  <= alu_my;
          state_q <= ST_CHK0;
        end
        ST_CHK0: begin
          f_q     <= alu_lt;
          state_q <= ST_CHK1;
        end
        ST_CHK1: begin
          if ((f_q && alu_lt) || (pc_lvl >= lim)) begin
            cap_q   <= !(f_q && alu_lt);
            state_q <= ST_LEAF0;
          end else begin
            state_q <= ST_SP_R2;
          end
        end
        ST_LEAF0: begin
          if (emit_ok) begin
            state_q <= ST_LEAF1;
          end
        end
        ST_LEAF1: begin
          if (emit_ok) begin
            state_q <= stk_empty ? ST_CARRY_U : ST_POP;
          end
        end
        // split: right half pushed first so the left half pops next
        ST_SP_R2: begin
          n2_q[0] <= alu_mx;
          n2_q[1] <= alu_my;
          state_q <= ST_SP_R4;
        end
        ST_SP_R4: begin
          n4_q[0] <= alu_mx;
          n4_q[1] <= alu_my;
          state_q <= ST_SP_L2;
        end
        ST_SP_L2: begin
          k2_q[0] <= alu_mx;
          k2_q[1] <= alu_my;
          state_q <= ST_SP_L4;
        end
        ST_SP_L4: begin
          k4_q[0] <= alu_mx;
          k4_q[1] <= alu_my;
          state_q <= ST_PUSH_R;
        end
        ST_PUSH_R: state_q <= ST_PUSH_L;
        ST_PUSH_L: state_q <= ST_POP;
        // segment done: advance the carried controls
        ST_CARRY_U: begin
          carry_q[0] <= e6_q[0];
          carry_q[1] <= e6_q[1];
          carry_q[2] <= alu_mx;
          carry_q[3] <= alu_my;
          prev_q     <= p_q;
          state_q    <= last_q ? ST_TAIL_MID : ST_IDLE;
        end
        ST_TAIL_MID: begin
          if (emit_ok) begin
            state_q <= ST_TAIL_END;
          end
        end
        ST_TAIL_END: begin
          if (emit_ok) begin
            points_seen_q <= 2'd0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_x_o        = out_x_q;
  assign out_y_o        = out_y_q;
  assign out_last_o     = out_last_q;
  assign depth_capped_o = out_capped_q;

  a_idle_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> stk_empty) else $error("osf: idle with pieces left on stack");

  a_points_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    points_seen_q != 2'd3) else $error("osf: bad point count");

  a_tail_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL_END) |-> last_q) else $error("osf: endpoint without last point");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for open_spline_flattener
// Streams control points through the block, predicts every polyline vertex
// with a fixed-point subdivision model of its own, and checks each vertex
// beat field by field under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  import osf_pkg::*;

  localparam int COORD_W        = COORD_BITS_DEF;
  localparam int FRAC_W         = FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES  = 20;    // covers a point that emits nothing
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any beat
  localparam int PHASE_POINTS   = 77;

  // Spline progress of the predictor: no point yet, one point, two or more
  typedef enum logic [1:0] {
    SPL_IDLE,
    SPL_ONE,
    SPL_RUN
  } spline_phase_e;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic                      capped;
  } vertex_t;

  // One curve piece: start, two inner controls, end (x, y interleaved)
  typedef struct {
    longint c [NUM_COORDS];
    int     lvl;
  } piece_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i;
  logic [CFG_DATA_W-1:0]        cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [COORD_W-1:0]    point_x_i;
  logic signed [COORD_W-1:0]    point_y_i;
  logic                         last_point_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [COORD_W-1:0]    out_x_o;
  logic signed [COORD_W-1:0]    out_y_o;
  logic                         out_last_o;
  logic                         depth_capped_o;

  // Expected vertices in output order, and the ones of the point being predicted
  vertex_t       vertex_q [$];
  vertex_t       item_verts [$];

  // Predictor copy of the registers and the spline state
  logic [THR_W-1:0] flat_thr  = THR_RESET;
  logic [LVL_W-1:0] depth_lim = DEPTH_RESET;
  spline_phase_e    spl_phase = SPL_IDLE;
  longint           prev_x    = 0;
  longint           prev_y    = 0;
  longint           carry_c [4] = '{0, 0, 0, 0};

  int  mismatches  = 0;
  int  points_sent = 0;
  int  idle_cycles = 0;
  bit  steady      = 1'b0;  // set: no gaps and no stalls on either side

  open_spline_flattener dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .last_point_i  (last_point_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_last_o    (out_last_o),
    .depth_capped_o(depth_capped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------

  // floor((a + b) / 2): arithmetic shift of the exact sum
  function automatic longint midpt(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Drop the fraction bits toward zero and keep the port width
  function automatic logic [COORD_W-1:0] to_pixel(longint raw);
    longint t;
    t = (raw < 0) ? -((-raw) >>> FRAC_W) : (raw >>> FRAC_W);
    return t[COORD_W-1:0];
  endfunction

  function automatic void add_vertex(longint x, longint y, logic capped);
    vertex_t v;
    v.x      = to_pixel(x);
    v.y      = to_pixel(y);
    v.last   = 1'b0;
    v.capped = capped;
    item_verts.push_back(v);
  endfunction

  // Depth-first midpoint subdivision: pop a piece, emit it when flat or at the
  // depth limit, else push its right half and then its left half.
  function automatic void flatten_segment(piece_t seg);
    piece_t stk [$];
    piece_t p;
    piece_t lh;
    piece_t rh;
    longint thr;
    longint xm;
    longint ym;
    int     lim;
    logic   flat;
    lim = int'(depth_lim);
    if (lim > HARD_DEPTH) lim = HARD_DEPTH;
    if (lim > STACK_ENTRIES_DEF - 1) lim = STACK_ENTRIES_DEF - 1;
    thr = longint'(flat_thr) << FRAC_W;
    stk.push_back(seg);
    while (stk.size() != 0) begin
      p    = stk.pop_back();
      xm   = midpt(p.c[2], p.c[4]);
      ym   = midpt(p.c[3], p.c[5]);
      flat = mag(p.c[0] - xm) < thr && mag(p.c[1] - ym) < thr &&
             mag(xm - p.c[6]) < thr && mag(ym - p.c[7]) < thr;
      if (flat || p.lvl >= lim) begin
        add_vertex(p.c[0], p.c[1], !flat);
        add_vertex(xm, ym, !flat);
      end else begin
        rh.c[0] = xm;                     rh.c[1] = ym;
        rh.c[2] = midpt(xm, p.c[4]);      rh.c[3] = midpt(ym, p.c[5]);
        rh.c[4] = midpt(p.c[4], p.c[6]);  rh.c[5] = midpt(p.c[5], p.c[7]);
        rh.c[6] = p.c[6];                 rh.c[7] = p.c[7];
        lh.c[0] = p.c[0];                 lh.c[1] = p.c[1];
        lh.c[2] = midpt(p.c[0], p.c[2]);  lh.c[3] = midpt(p.c[1], p.c[3]);
        lh.c[4] = midpt(p.c[2], xm);      lh.c[5] = midpt(p.c[3], ym);
        lh.c[6] = xm;                     lh.c[7] = ym;
        rh.lvl  = p.lvl + 1;
        lh.lvl  = p.lvl + 1;
        stk.push_back(rh);
        stk.push_back(lh);
      end
    end
  endfunction

  // Advance the spline state by one accepted point and queue its vertices
  function automatic void predict_vertices(logic signed [COORD_W-1:0] x,
                                           logic signed [COORD_W-1:0] y,
                                           logic lst);
    piece_t seg;
    longint px;
    longint py;
    px = longint'(x) <<< FRAC_W;
    py = longint'(y) <<< FRAC_W;
    item_verts.delete();
    case (spl_phase)
      SPL_IDLE: begin
        add_vertex(px, py, 1'b0);
        spl_phase = SPL_ONE;
      end
      SPL_ONE: begin
        carry_c[0] = midpt(prev_x, px);
        carry_c[1] = midpt(prev_y, py);
        carry_c[2] = midpt(carry_c[0], px);
        carry_c[3] = midpt(carry_c[1], py);
        spl_phase  = SPL_RUN;
      end
      default: begin
        seg.c[0] = carry_c[0];
        seg.c[1] = carry_c[1];
        seg.c[2] = carry_c[2];
        seg.c[3] = carry_c[3];
        seg.c[6] = midpt(prev_x, px);
        seg.c[7] = midpt(prev_y, py);
        seg.c[4] = midpt(prev_x, seg.c[6]);
        seg.c[5] = midpt(prev_y, seg.c[7]);
        seg.lvl  = 0;
        flatten_segment(seg);
        carry_c[0] = seg.c[6];
        carry_c[1] = seg.c[7];
        carry_c[2] = midpt(seg.c[6], px);
        carry_c[3] = midpt(seg.c[7], py);
      end
    endcase
    prev_x = px;
    prev_y = py;
    if (lst) begin
      // close the spline with the carried midpoint and the endpoint
      if (spl_phase == SPL_RUN) begin
        add_vertex(carry_c[0], carry_c[1], 1'b0);
        add_vertex(px, py, 1'b0);
      end
      spl_phase = SPL_IDLE;
    end
    if (item_verts.size() != 0) item_verts[item_verts.size() - 1].last = 1'b1;
    foreach (item_verts[i]) vertex_q.push_back(item_verts[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Send one control point: idle a random number of cycles, then hold valid
  // and the payload until the beat is taken. Valid stays high after the beat
  // so a following point with no gap goes out back to back.
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic lst);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    point_x_i    = x;
    point_y_i    = y;
    last_point_i = lst;
    do @(posedge clk_i); while (!in_ready_o);
    predict_vertices(x, y, lst);
    points_sent++;
  endtask

  // Drop valid, wait for every expected vertex, then let a trailing point
  // that emits nothing finish inside the block.
  task automatic drain_vertices();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register while the block is idle and mirror it in the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain_vertices();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FLAT_THRESHOLD: flat_thr  = val[THR_W-1:0];
      CFG_DEPTH_LIMIT:    depth_lim = val[LVL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input int thr, input int depth);
    write_reg(CFG_FLAT_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_DEPTH_LIMIT, CFG_DATA_W'(depth));
  endtask

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Random spline: mostly a walk of nearby points so flat and split pieces
  // mix, with some jumps across the full range and some corner values.
  task automatic send_random_spline(input int span);
    int len;
    int k;
    int pick;
    int cx;
    int cy;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
    cx  = int'($urandom_range(0, 65535)) - 32768;
    cy  = int'($urandom_range(0, 65535)) - 32768;
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        cx = clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span);
        cy = clamp_coord(cy + int'($urandom_range(0, 2 * span)) - span);
      end else if (pick < 9) begin
        cx = int'($urandom_range(0, 65535)) - 32768;
        cy = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        cx = corner_coord();
        cy = corner_coord();
      end
      send_point(cx[COORD_W-1:0], cy[COORD_W-1:0], k == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values of both registers; a lone point emits only itself
  task automatic test_single_point();
    send_point(16'sd0, 16'sd0, 1'b1);
  endtask

  // Second point as the end: midpoint and endpoint, across the full range
  task automatic test_two_point();
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1);
  endtask

  // Opposite corners force every piece to the depth limit
  task automatic test_extreme_corners();
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, -16'sd32768, 1'b1);
    // short straight run: flat on the first piece
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b1);
  endtask

  // Zero threshold: nothing is flat, the last point emits the most vertices
  task automatic test_zero_threshold();
    set_config(0, 4);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
  endtask

  // Depth limit above range acts as the hard limit; depth zero emits the
  // whole segment as one piece
  task automatic test_depth_limits();
    set_config(255, 7);
    send_point(16'sd100, -16'sd100, 1'b0);
    send_point(-16'sd100, 16'sd100, 1'b0);
    send_point(16'sd50, 16'sd50, 1'b0);
    send_point(-16'sd1, -16'sd1, 1'b1);
    set_config(1, 0);
    send_point(16'sd10, 16'sd20, 1'b0);
    send_point(-16'sd30, 16'sd40, 1'b0);
    send_point(-16'sd7, -16'sd9, 1'b1);
  endtask

  // Small negative coordinates check truncation toward zero
  task automatic test_negative_truncation();
    set_config(1, 4);
    send_point(-16'sd1, -16'sd3, 1'b0);
    send_point(-16'sd2, 16'sd5, 1'b0);
    send_point(16'sd3, -16'sd4, 1'b1);
  endtask

  // Random splines over several register settings; one phase runs with no
  // gaps or stalls, and the sender pauses for a full drain now and then
  task automatic test_random_splines();
    int ph;
    int goal;
    int span;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin set_config(5, 4); span = 30; end
        1: begin set_config($urandom_range(1, 20), $urandom_range(0, 4)); span = 200; end
        2: begin set_config(255, $urandom_range(5, 7)); span = 4000; end
        3: begin set_config(1, $urandom_range(0, 7)); span = 8; end
        4: begin
          set_config($urandom_range(1, 255), $urandom_range(0, 7));
          span = 8 * int'(flat_thr) + 1;
        end
        default: begin set_config(0, $urandom_range(0, 2)); span = 100; end
      endcase
      steady = (ph == 3);
      goal   = points_sent + PHASE_POINTS;
      while (points_sent < goal) begin
        send_random_spline(span);
        if ($urandom_range(0, 15) == 0) drain_vertices();
      end
      steady = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Vertex sink: stall a random number of cycles per vertex, then take it
  // --------------------------------------------------------------------------
  initial begin : vertex_sink
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every vertex beat with the oldest expected vertex
  always @(posedge clk_i) begin : vertex_checker
    vertex_t exp_v;
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      if (vertex_q.size() == 0) begin
        $error("vertex (%0d, %0d) with nothing expected", out_x_o, out_y_o);
        mismatches++;
      end else begin
        exp_v = vertex_q.pop_front();
        if (out_x_o !== exp_v.x) begin
          $error("out_x expected %0d got %0d", exp_v.x, out_x_o);
          mismatches++;
        end
        if (out_y_o !== exp_v.y) begin
          $error("out_y expected %0d got %0d", exp_v.y, out_y_o);
          mismatches++;
        end
        if (out_last_o !== exp_v.last) begin
          $error("out_last expected %0d got %0d", exp_v.last, out_last_o);
          mismatches++;
        end
        if (depth_capped_o !== exp_v.capped) begin
          $error("depth_capped expected %0d got %0d", exp_v.capped, depth_capped_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_FLAT_THRESHOLD;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    point_x_i    = '0;
    point_y_i    = '0;
    last_point_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_point();
    test_two_point();
    test_extreme_corners();
    test_zero_threshold();
    test_depth_limits();
    test_negative_truncation();
    test_random_splines();

    drain_vertices();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
